// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the list unit RTL.
// The macros refer to the clk and rst_n signals of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define MRU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition in one cycle that implies a condition in the next cycle.
`define MRU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

// ===== rtl/mru_pkg.sv =====
// Package of the move-to-front list unit: action and register codes, widths,
// controller state type and the controller/datapath interface structs. No dependencies.
package mru_pkg;

  localparam int CNT_W      = 5;
  localparam int SLOT_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [CNT_W-1:0] SHOW_RESET = 5'd4;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SET = 2'd1,
    ACT_GET = 2'd2,
    ACT_DEL = 2'd3
  } action_t;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ID_BASE  = 2'd2;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_UPD  = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/mru_ctrl.sv =====
// Controller of the move-to-front list unit: accepts one item, then commits its update.
// Depends on mru_pkg.
module mru_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  mru_pkg::dp_status_t    status,
  output mru_pkg::ctrl_cmd_t     cmd
);

  mru_pkg::state_t state_r;
  mru_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mru_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mru_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = mru_pkg::ST_UPD;
        end
      end
      mru_pkg::ST_UPD: begin
        if (status.out_free) begin
          state_nxt = mru_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mru_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      mru_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      mru_pkg::ST_UPD: begin
        cmd.commit = status.out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

endmodule

// ===== rtl/mru_dp.sv =====
// Datapath of the move-to-front list unit: key list, fill count, configuration
// registers, key compare, list update and result register. Depends on mru_pkg.
module mru_dp #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mru_pkg::ctrl_cmd_t               cmd,
  output mru_pkg::dp_status_t              status,
  input  logic [1:0]                       in_action,
  input  logic [KEY_BITS-1:0]              in_item_key,
  input  logic [mru_pkg::SLOT_W-1:0]       in_slot_index,
  input  logic                             in_id_based,
  input  logic                             cfg_we,
  input  logic [mru_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mru_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_ok,
  output logic [KEY_BITS-1:0]              out_read_key,
  output logic                             out_was_present,
  output logic [mru_pkg::CNT_W-1:0]        out_fill_count,
  output logic [mru_pkg::CNT_W-1:0]        out_visible_count
);

  localparam int CW    = mru_pkg::CNT_W;
  localparam int SW    = mru_pkg::SLOT_W;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int IW    = IDX_W + 1;
  localparam int WW    = (IW > CW) ? IW : CW;
  localparam logic [CW-1:0] CAP_RST =
    (WW'(MAX_ENTRIES) < WW'(mru_pkg::CAP_RESET)) ? CW'(MAX_ENTRIES) : mru_pkg::CAP_RESET;
  localparam logic [CW-1:0] SHOW_RST =
    (CAP_RST < mru_pkg::SHOW_RESET) ? CAP_RST : mru_pkg::SHOW_RESET;

  logic [KEY_BITS-1:0]    entries_r   [MAX_ENTRIES];
  logic [KEY_BITS-1:0]    entries_nxt [MAX_ENTRIES];
  logic [CW-1:0]          filled_r;
  logic [CW-1:0]          filled_nxt;
  logic [CW-1:0]          capacity_r;
  logic [CW-1:0]          show_r;
  logic [SW-1:0]          id_base_r;

  mru_pkg::action_t       act_r;
  logic [KEY_BITS-1:0]    key_in_r;
  logic [SW-1:0]          slot_r;
  logic [MAX_ENTRIES-1:0] hit_r;
  logic [MAX_ENTRIES-1:0] hit_nxt;
  logic [SW-1:0]          slot_nxt;

  logic                   out_valid_r;
  logic                   out_ok_r;
  logic [KEY_BITS-1:0]    out_read_key_r;
  logic                   out_was_present_r;
  logic [CW-1:0]          out_fill_count_r;
  logic [CW-1:0]          out_visible_count_r;

  logic                   present;
  logic [MAX_ENTRIES-1:0] hit_below;
  logic [CW:0]            sum1;
  logic [CW-1:0]          grow;
  logic                   slot_lt_fill;
  logic                   slot_lt_cap;
  logic [CW-1:0]          fill_dec;
  logic [IDX_W-1:0]       slot_i;
  logic                   ok_nxt;
  logic [KEY_BITS-1:0]    rd_nxt;
  logic [CW-1:0]          vis_nxt;
  logic [CW-1:0]          cap_wr;
  logic [CW-1:0]          show_wr;
  logic [CW-1:0]          cfg_val;

  assign status.out_free = !out_valid_r || !out_stall;

  // Key compare and slot rebasing at the accepting edge.
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_nxt[i] = (WW'(i) < WW'(filled_r)) && (entries_r[i] == in_item_key);
    end
    if (in_id_based && (mru_pkg::action_t'(in_action) != mru_pkg::ACT_SET)) begin
      slot_nxt = in_slot_index - id_base_r - SW'(1);
    end else begin
      slot_nxt = in_slot_index;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r    <= mru_pkg::action_t'(in_action);
      key_in_r <= in_item_key;
      slot_r   <= slot_nxt;
      hit_r    <= hit_nxt;
    end
  end

  always_comb begin
    present = |hit_r;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_below[i] = |(hit_r & ({MAX_ENTRIES{1'b1}} >> (MAX_ENTRIES - i)));
    end
    sum1         = {1'b0, filled_r} + (CW + 1)'(1);
    grow         = (sum1 < {1'b0, capacity_r}) ? sum1[CW-1:0] : capacity_r;
    slot_lt_fill = slot_r < SW'(filled_r);
    slot_lt_cap  = slot_r < SW'(capacity_r);
    fill_dec     = filled_r - CW'(1);
    slot_i       = slot_r[IDX_W-1:0];
  end

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      entries_nxt[i] = entries_r[i];
    end
    filled_nxt = filled_r;
    ok_nxt     = 1'b0;
    rd_nxt     = '0;
    unique case (act_r)
      mru_pkg::ACT_ADD: begin
        ok_nxt = 1'b1;
        if (!present) begin
          filled_nxt = grow;
        end
        entries_nxt[0] = key_in_r;
        for (int i = 1; i < MAX_ENTRIES; i++) begin
          if (present ? !hit_below[i] : (WW'(i) < WW'(grow))) begin
            entries_nxt[i] = entries_r[i-1];
          end
        end
      end
      mru_pkg::ACT_SET: begin
        if (slot_lt_cap) begin
          ok_nxt              = 1'b1;
          entries_nxt[slot_i] = key_in_r;
          if (filled_r < (slot_r[CW-1:0] + CW'(1))) begin
            filled_nxt = slot_r[CW-1:0] + CW'(1);
          end
        end
      end
      mru_pkg::ACT_GET: begin
        if (slot_lt_fill) begin
          ok_nxt = 1'b1;
          rd_nxt = entries_r[slot_i];
        end
      end
      mru_pkg::ACT_DEL: begin
        if (slot_lt_fill) begin
          ok_nxt     = 1'b1;
          filled_nxt = fill_dec;
          for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
            if ((SW'(i) >= slot_r) && (WW'(i) < WW'(fill_dec))) begin
              entries_nxt[i] = entries_r[i+1];
            end
          end
        end
      end
      default: ok_nxt = 1'b0;
    endcase
    vis_nxt = (filled_nxt < show_r) ? filled_nxt : show_r;
  end

  // Configuration write values with their clamps.
  always_comb begin
    cfg_val = cfg_data[CW-1:0];
    if (cfg_val == '0) begin
      cap_wr = CW'(1);
    end else if (WW'(cfg_val) > WW'(MAX_ENTRIES)) begin
      cap_wr = CW'(MAX_ENTRIES);
    end else begin
      cap_wr = cfg_val;
    end
    show_wr = (cfg_val > capacity_r) ? capacity_r : cfg_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RST;
      show_r     <= SHOW_RST;
      id_base_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mru_pkg::REG_CAPACITY: capacity_r <= cap_wr;
        mru_pkg::REG_SHOW:     show_r     <= show_wr;
        mru_pkg::REG_ID_BASE:  id_base_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        entries_r[i] <= '0;
      end
      filled_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        entries_r[i] <= entries_nxt[i];
      end
      filled_r    <= filled_nxt;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_ok_r            <= ok_nxt;
      out_read_key_r      <= rd_nxt;
      out_was_present_r   <= (act_r == mru_pkg::ACT_ADD) && present;
      out_fill_count_r    <= filled_nxt;
      out_visible_count_r <= vis_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_read_key      = out_read_key_r;
  assign out_was_present   = out_was_present_r;
  assign out_fill_count    = out_fill_count_r;
  assign out_visible_count = out_visible_count_r;

endmodule

// ===== rtl/mru_move_to_front_list_unit.sv =====
// Move-to-front list unit. The accepting edge registers the key compares against all
// slots, and the commit edge then updates the list and loads the result register.
// One item is in work at a time: a new item is taken only once the last one has
// committed; a stalled result holds the update stage until it is taken.
// Synchronous active-low reset clears all keys, the fill count and the result valid,
// and loads capacity min(16, MAX_ENTRIES), show limit 4 (clamped) and id base 0.
`include "assert_macros.svh"

module mru_move_to_front_list_unit #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_action,
  input  logic [KEY_BITS-1:0]              in_item_key,
  input  logic [mru_pkg::SLOT_W-1:0]       in_slot_index,
  input  logic                             in_id_based,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_ok,
  output logic [KEY_BITS-1:0]              out_read_key,
  output logic                             out_was_present,
  output logic [mru_pkg::CNT_W-1:0]        out_fill_count,
  output logic [mru_pkg::CNT_W-1:0]        out_visible_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mru_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mru_pkg::CFG_DATA_W-1:0]   cfg_data
);

  mru_pkg::ctrl_cmd_t  cmd;
  mru_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  mru_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mru_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_action         (in_action),
    .in_item_key       (in_item_key),
    .in_slot_index     (in_slot_index),
    .in_id_based       (in_id_based),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ok            (out_ok),
    .out_read_key      (out_read_key),
    .out_was_present   (out_was_present),
    .out_fill_count    (out_fill_count),
    .out_visible_count (out_visible_count)
  );

  `MRU_ASSERT_NEXT(a_single_item, in_valid && !in_stall, in_stall, "item accepted while busy")
  `MRU_ASSERT(a_visible_le_fill, out_valid |-> out_visible_count <= out_fill_count, "visible above fill")
  `MRU_ASSERT(a_fail_no_key, out_valid && !out_ok |-> out_read_key == '0, "key on failed action")

endmodule

// ===== sim/mru_move_to_front_list_unit_tb.sv =====
// Self-checking testbench for the move-to-front list unit: a directed table, partly with fixed expected results,
// then random list actions over several register settings, checked against an in-bench list model.
// Depends on mru_pkg and mru_move_to_front_list_unit.
module mru_move_to_front_list_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ENTRIES  = 16;
  localparam int KEY_BITS     = 64;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES  = 80;
  localparam int PHASE_ITEMS  = 55;
  localparam int NUM_PHASES   = 8;
  localparam int DIR_ROWS     = 21;
  localparam int CW           = mru_pkg::CNT_W;

  typedef struct packed {
    logic                ok;
    logic [KEY_BITS-1:0] read_key;
    logic                was_present;
    logic [CW-1:0]       fill;
    logic [CW-1:0]       visible;
  } list_result_t;

  typedef struct packed {
    mru_pkg::action_t           act;
    logic [KEY_BITS-1:0]        key;
    logic [mru_pkg::SLOT_W-1:0] slot;
    logic                       idb;
    logic                       typed;
    list_result_t               want;
  } dir_row_t;

  typedef struct packed {
    logic [mru_pkg::CFG_DATA_W-1:0] cap_data;
    logic [mru_pkg::CFG_DATA_W-1:0] show_data;
    logic [mru_pkg::CFG_DATA_W-1:0] base_data;
    logic                           show_first;
    logic                           hold;
  } phase_cfg_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_RANDOM,
    RX_PERIODIC
  } rx_mode_t;

  localparam list_result_t NO_RES = '0;
  localparam logic [KEY_BITS-1:0] ONES_KEY = '1;
  localparam logic [KEY_BITS-1:0] A5_KEY = 64'hA5A5A5A5_5A5A5A5A;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [1:0]                     in_action = '0;
  logic [KEY_BITS-1:0]            in_item_key = '0;
  logic [mru_pkg::SLOT_W-1:0]     in_slot_index = '0;
  logic                           in_id_based = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           out_ok;
  logic [KEY_BITS-1:0]            out_read_key;
  logic                           out_was_present;
  logic [CW-1:0]                  out_fill_count;
  logic [CW-1:0]                  out_visible_count;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [mru_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [mru_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  mru_move_to_front_list_unit uut (.*);

  logic [KEY_BITS-1:0]        list_keys [MAX_ENTRIES];
  logic [CW-1:0]              list_fill;
  logic [CW-1:0]              cap_shadow;
  logic [CW-1:0]              show_shadow;
  logic [mru_pkg::SLOT_W-1:0] base_shadow;

  list_result_t pending_results [$];
  int err_count = 0;
  int results_checked = 0;
  int present_hits = 0;
  int items_sent = 0;
  int burst_left = 0;
  int cycle_count = 0;
  int hold_requests = 0;
  int hold_served = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{mru_pkg::ACT_GET, 64'h0, 16'd0, 1'b0, 1'b1, '{1'b0, 64'h0, 1'b0, 5'd0, 5'd0}},
    '{mru_pkg::ACT_DEL, 64'h0, 16'd0, 1'b0, 1'b1, '{1'b0, 64'h0, 1'b0, 5'd0, 5'd0}},
    '{mru_pkg::ACT_ADD, 64'h0, 16'd0, 1'b0, 1'b1, '{1'b1, 64'h0, 1'b0, 5'd1, 5'd1}},
    '{mru_pkg::ACT_ADD, ONES_KEY, 16'd0, 1'b0, 1'b1, '{1'b1, 64'h0, 1'b0, 5'd2, 5'd2}},
    '{mru_pkg::ACT_ADD, 64'h0, 16'd0, 1'b0, 1'b1, '{1'b1, 64'h0, 1'b1, 5'd2, 5'd2}},
    '{mru_pkg::ACT_SET, A5_KEY, 16'd15, 1'b0, 1'b1, '{1'b1, 64'h0, 1'b0, 5'd16, 5'd4}},
    '{mru_pkg::ACT_SET, 64'h1, 16'd16, 1'b0, 1'b1, '{1'b0, 64'h0, 1'b0, 5'd16, 5'd4}},
    '{mru_pkg::ACT_SET, 64'h2, 16'hFFFF, 1'b1, 1'b1, '{1'b0, 64'h0, 1'b0, 5'd16, 5'd4}},
    '{mru_pkg::ACT_GET, 64'h0, 16'd15, 1'b0, 1'b1, '{1'b1, A5_KEY, 1'b0, 5'd16, 5'd4}},
    '{mru_pkg::ACT_GET, 64'h0, 16'd16, 1'b0, 1'b1, '{1'b0, 64'h0, 1'b0, 5'd16, 5'd4}},
    '{mru_pkg::ACT_GET, 64'h0, 16'd0, 1'b1, 1'b1, '{1'b0, 64'h0, 1'b0, 5'd16, 5'd4}},
    '{mru_pkg::ACT_GET, 64'h0, 16'd1, 1'b1, 1'b1, '{1'b1, 64'h0, 1'b0, 5'd16, 5'd4}},
    '{mru_pkg::ACT_SET, 64'h3C3C3C3C_C3C3C3C3, 16'd3, 1'b1, 1'b0, NO_RES},
    '{mru_pkg::ACT_ADD, 64'h01234567_89ABCDEF, 16'd0, 1'b0, 1'b0, NO_RES},
    '{mru_pkg::ACT_ADD, ONES_KEY, 16'd0, 1'b0, 1'b0, NO_RES},
    '{mru_pkg::ACT_DEL, 64'h0, 16'd0, 1'b0, 1'b0, NO_RES},
    '{mru_pkg::ACT_DEL, 64'h0, 16'd8, 1'b1, 1'b0, NO_RES},
    '{mru_pkg::ACT_DEL, 64'h0, 16'hFFFF, 1'b0, 1'b0, NO_RES},
    '{mru_pkg::ACT_GET, 64'h0, 16'd0, 1'b0, 1'b0, NO_RES},
    '{mru_pkg::ACT_ADD, 64'h80000000_00000000, 16'd0, 1'b0, 1'b0, NO_RES},
    '{mru_pkg::ACT_GET, 64'h0, 16'hFFFF, 1'b1, 1'b0, NO_RES}
  };

  phase_cfg_t phases [NUM_PHASES] = '{
    '{16'd16,   16'd16, 16'h0000, 1'b0, 1'b0},
    '{16'hFFE3, 16'd31, 16'hFFFF, 1'b0, 1'b1},
    '{16'd0,    16'd0,  16'h0001, 1'b0, 1'b0},
    '{16'd31,   16'd5,  16'h8000, 1'b0, 1'b0},
    '{16'd8,    16'd16, 16'h7FFF, 1'b1, 1'b0},
    '{16'd2,    16'd1,  16'h5A5A, 1'b0, 1'b1},
    '{16'd16,   16'd4,  16'h0000, 1'b0, 1'b0},
    '{16'd12,   16'd16, 16'hA5A5, 1'b0, 1'b0}
  };

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("[mru_move_to_front_list_unit] ERROR");
    $finish;
  end

  function automatic void list_reset();
    foreach (list_keys[i]) list_keys[i] = '0;
    list_fill = '0;
    cap_shadow = mru_pkg::CAP_RESET;
    show_shadow = mru_pkg::SHOW_RESET;
    base_shadow = '0;
  endfunction

  function automatic void cfg_shadow_write(logic [mru_pkg::CFG_IDX_W-1:0] idx,
                                           logic [mru_pkg::CFG_DATA_W-1:0] data);
    logic [CW-1:0] v;
    v = data[CW-1:0];
    if (idx == mru_pkg::REG_CAPACITY) begin
      if (v == '0) cap_shadow = CW'(1);
      else if (32'(v) > MAX_ENTRIES) cap_shadow = CW'(MAX_ENTRIES);
      else cap_shadow = v;
    end else if (idx == mru_pkg::REG_SHOW) begin
      show_shadow = (v > cap_shadow) ? cap_shadow : v;
    end else if (idx == mru_pkg::REG_ID_BASE) begin
      base_shadow = data;
    end
  endfunction

  function automatic list_result_t mtf_apply_action(mru_pkg::action_t act,
                                                    logic [KEY_BITS-1:0] key,
                                                    logic [mru_pkg::SLOT_W-1:0] raw,
                                                    logic idb);
    list_result_t res;
    logic [mru_pkg::SLOT_W-1:0] slot;
    int hit;
    int i;
    bit found;
    res = '0;
    slot = idb ? raw - base_shadow - 16'd1 : raw;
    hit = 0;
    found = 1'b0;
    case (act)
      mru_pkg::ACT_ADD: begin
        res.ok = 1'b1;
        for (i = 0; i < list_fill && i < MAX_ENTRIES; i++) begin
          if (!found && list_keys[i] == key) begin
            found = 1'b1;
            hit = i;
          end
        end
        if (!found) begin
          list_fill = (32'(list_fill) + 1 < 32'(cap_shadow)) ? list_fill + CW'(1) : cap_shadow;
          hit = int'(list_fill) - 1;
        end
        for (i = hit; i > 0; i--) list_keys[i] = list_keys[i-1];
        list_keys[0] = key;
        res.was_present = found;
      end
      mru_pkg::ACT_SET: begin
        if (raw < cap_shadow) begin
          res.ok = 1'b1;
          list_keys[raw] = key;
          if (32'(list_fill) < 32'(raw) + 1) list_fill = CW'(raw + 16'd1);
        end
      end
      mru_pkg::ACT_GET: begin
        if (slot < list_fill) begin
          res.ok = 1'b1;
          res.read_key = list_keys[slot];
        end
      end
      default: begin
        if (slot < list_fill) begin
          res.ok = 1'b1;
          list_fill = list_fill - CW'(1);
          for (i = slot; i < list_fill; i++) list_keys[i] = list_keys[i+1];
        end
      end
    endcase
    res.fill = list_fill;
    res.visible = (list_fill < show_shadow) ? list_fill : show_shadow;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= 20) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with no expected result");
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.was_present) present_hits++;
        if (out_ok !== want.ok)
          report_mismatch($sformatf("ok %b, expected %b", out_ok, want.ok));
        if (out_read_key !== want.read_key)
          report_mismatch($sformatf("read_key %h, expected %h", out_read_key, want.read_key));
        if (out_was_present !== want.was_present)
          report_mismatch($sformatf("was_present %b, expected %b", out_was_present,
                                    want.was_present));
        if (out_fill_count !== want.fill)
          report_mismatch($sformatf("fill_count %0d, expected %0d", out_fill_count,
                                    want.fill));
        if (out_visible_count !== want.visible)
          report_mismatch($sformatf("visible_count %0d, expected %0d", out_visible_count,
                                    want.visible));
      end
    end
  end

  always @(negedge clk) begin
    int rx_cycle;
    int hold_left;
    rx_mode_t rx_mode;
    rx_cycle++;
    if (hold_requests != hold_served) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
    end
    if (rx_cycle % 128 == 0) rx_mode = rx_mode_t'($urandom_range(0, 2));
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        RX_FREE:   out_stall <= 1'b0;
        RX_RANDOM: out_stall <= ($urandom_range(0, 99) < 35);
        default:   out_stall <= (rx_cycle % 7 < 3);
      endcase
    end
  end

  task automatic send_item(mru_pkg::action_t act, logic [KEY_BITS-1:0] key,
                           logic [mru_pkg::SLOT_W-1:0] slot,
                           logic idb, logic typed, list_result_t want);
    list_result_t predicted;
    int gap;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_item_key <= key;
    in_slot_index <= slot;
    in_id_based <= idb;
    do @(posedge clk); while (in_stall);
    predicted = mtf_apply_action(act, key, slot, idb);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_put(logic [mru_pkg::CFG_IDX_W-1:0] idx,
                         logic [mru_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_shadow_write(idx, data);
    @(negedge clk);
  endtask

  initial begin
    logic [KEY_BITS-1:0] key_pool [8];
    logic [KEY_BITS-1:0] key;
    logic [mru_pkg::SLOT_W-1:0] slot;
    logic idb;
    mru_pkg::action_t act;
    int r;
    int tgt;
    list_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].act, dir_rows[i].key, dir_rows[i].slot, dir_rows[i].idb,
                dir_rows[i].typed, dir_rows[i].want);
    in_valid <= 1'b0;

    foreach (phases[p]) begin
      wait_idle();
      if (phases[p].show_first) begin
        cfg_put(mru_pkg::REG_SHOW, phases[p].show_data);
        cfg_put(mru_pkg::REG_CAPACITY, phases[p].cap_data);
      end else begin
        cfg_put(mru_pkg::REG_CAPACITY, phases[p].cap_data);
        cfg_put(mru_pkg::REG_SHOW, phases[p].show_data);
      end
      cfg_put(mru_pkg::REG_ID_BASE, phases[p].base_data);
      cfg_valid <= 1'b0;
      if (phases[p].hold) hold_requests++;
      key_pool[0] = '0;
      key_pool[1] = ONES_KEY;
      for (int k = 2; k < 8; k++) key_pool[k] = {$urandom(), $urandom()};
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          act = mru_pkg::action_t'($urandom_range(0, 3));
          key = {$urandom(), $urandom()};
          slot = 16'($urandom());
          idb = 1'($urandom());
        end else begin
          r = $urandom_range(0, 99);
          act = (r < 40) ? mru_pkg::ACT_ADD : (r < 55) ? mru_pkg::ACT_SET :
                (r < 80) ? mru_pkg::ACT_GET : mru_pkg::ACT_DEL;
          key = key_pool[$urandom_range(0, 7)];
          idb = 1'($urandom_range(0, 1));
          if (act == mru_pkg::ACT_SET) begin
            slot = 16'($urandom_range(0, cap_shadow));
          end else if (act == mru_pkg::ACT_ADD) begin
            slot = 16'($urandom());
          end else begin
            tgt = $urandom_range(0, list_fill);
            slot = idb ? 16'(tgt) + base_shadow + 16'd1 : 16'(tgt);
          end
        end
        send_item(act, key, slot, idb, 1'b0, NO_RES);
      end
      in_valid <= 1'b0;
    end

    wait_idle();
    $display("Run covered %0d list actions under %0d register settings, with two long",
             items_sent, NUM_PHASES + 1);
    $display("receiver hold-offs; %0d results checked, %0d of them moves of a listed key.",
             results_checked, present_hits);
    if (err_count == 0) begin
      $display("[mru_move_to_front_list_unit] OK");
    end else begin
      $display("[mru_move_to_front_list_unit] ERROR");
    end
    $finish;
  end

endmodule
